FILE: rtl/apfc_pkg.sv
// Shared types, widths and constants of the averaged PID fan controller.
`default_nettype none

package apfc_pkg;

  // Probe input words that exist on the ports.
  localparam int PROBE_FIELDS = 5;

  localparam int WORD_W    = 32;
  localparam int FAULT_BIT = 24;
  localparam int TEMP_W    = 32;
  localparam int GAIN_W    = 24;
  localparam int DUTY_W    = 8;
  localparam int CFG_IDX_W = 3;

  // Error, derivative and integral widths of the PID.
  localparam int ERR_W  = TEMP_W + 1;
  localparam int DIFF_W = TEMP_W + 2;
  localparam int OPER_W = 48;

  // Probe sum, its magnitude and the divisor (count of valid probes, at most five).
  localparam int DVD_W = TEMP_W + 3;
  localparam int MAG_W = DVD_W - 1;
  localparam int DSR_W = 3;

  // Multiply-accumulate: operands are cut into 16-bit chunks.
  localparam int CHUNK_W   = 16;
  localparam int NUM_CHUNK = OPER_W / CHUNK_W;
  localparam int NUM_TERM  = 3;
  localparam int PROD_W    = GAIN_W + 1 + CHUNK_W + 1;
  localparam int ACC_W     = 76;
  localparam int SHIFT_OUT = 26;
  localparam int DUTY_MAX  = 255;

  // Register reset values.
  localparam logic [TEMP_W-1:0] TARGET_RST = 32'd40960;
  localparam logic [GAIN_W-1:0] PGAIN_RST  = 24'd65536;
  localparam logic [GAIN_W-1:0] IGAIN_RST  = 24'd6554;
  localparam logic [GAIN_W-1:0] DGAIN_RST  = 24'd6554;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET     = 3'd0,
    REG_PGAIN      = 3'd1,
    REG_IGAIN      = 3'd2,
    REG_DGAIN      = 3'd3,
    REG_MAN_ENABLE = 3'd4,
    REG_MAN_DUTY   = 3'd5
  } reg_idx_e;

  // Start request of the serial divider.
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;  // two's complement
    logic [DSR_W-1:0] divisor;   // 1 to 5
  } div_req_t;

  // Multiply-accumulate operands; the user must hold them stable while it runs.
  typedef struct packed {
    logic                             start;
    logic [NUM_TERM-1:0][GAIN_W-1:0]  gain;
    logic [NUM_TERM-1:0][OPER_W-1:0]  oper;  // two's complement
  } mac_req_t;

endpackage

`default_nettype wire

FILE: rtl/apfc_div.sv
// Serial restoring divider: signed probe sum divided by the valid probe count.
`default_nettype none

module apfc_div import apfc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire div_req_t          req_i,
  output logic                   done_o,
  output logic [TEMP_W-1:0]      quot_o
);

  localparam int STEP_W = $clog2(MAG_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic              neg_q;
  logic [MAG_W-1:0]  mag_q;
  logic [DSR_W-1:0]  rem_q;
  logic [DSR_W-1:0]  dsr_q;

  logic [DSR_W:0]    trial;
  logic [DSR_W:0]    trial_diff;
  logic              trial_ge;
  logic [DSR_W-1:0]  rem_d;
  logic [DVD_W-1:0]  abs_dvd;
  logic [TEMP_W-1:0] quot_mag;

  assign trial      = {rem_q, mag_q[MAG_W-1]};
  assign trial_diff = trial - {1'b0, dsr_q};
  assign trial_ge   = (trial >= {1'b0, dsr_q});
  // The remainder stays below the divisor, so it fits the divisor width.
  assign rem_d      = trial_ge ? trial_diff[DSR_W-1:0] : trial[DSR_W-1:0];

  assign abs_dvd = req_i.dividend[DVD_W-1] ? (~req_i.dividend + DVD_W'(1)) : req_i.dividend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (step_q == LAST_STEP);
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // The quotient bits shift in at the bottom while the dividend shifts out at the top.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[DVD_W-1];
      mag_q <= abs_dvd[MAG_W-1:0];
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      mag_q <= {mag_q[MAG_W-2:0], trial_ge};
      rem_q <= rem_d;
    end
  end

  assign quot_mag = mag_q[TEMP_W-1:0];
  assign quot_o   = neg_q ? (~quot_mag + TEMP_W'(1)) : quot_mag;
  assign done_o   = done_q;

endmodule

`default_nettype wire

FILE: rtl/apfc_mac.sv
// Chunked multiply-accumulate of the three PID terms with output clamp.
`default_nettype none

module apfc_mac import apfc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mac_req_t          req_i,
  output logic                   done_o,
  output logic [DUTY_W-1:0]      duty_o
);

  localparam int TERM_W  = $clog2(NUM_TERM);
  localparam int CIDX_W  = $clog2(NUM_CHUNK);
  localparam int QUOT_W  = ACC_W - SHIFT_OUT;
  localparam logic [TERM_W-1:0] LAST_TERM  = TERM_W'(NUM_TERM - 1);
  localparam logic [CIDX_W-1:0] LAST_CHUNK = CIDX_W'(NUM_CHUNK - 1);

  logic                     issue_q;
  logic                     pend_q;
  logic                     pend_last_q;
  logic                     done_q;
  logic [TERM_W-1:0]        term_q;
  logic [CIDX_W-1:0]        chunk_q;
  logic [CIDX_W-1:0]        pend_chunk_q;
  logic signed [PROD_W-1:0] mult_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic [GAIN_W-1:0]        sel_gain;
  logic [OPER_W-1:0]        sel_oper;
  logic [CHUNK_W-1:0]       chunk_bits;
  logic                     chunk_ext;
  logic signed [PROD_W-1:0] mult_d;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  addend_sh;
  logic                     issue_last;
  logic [QUOT_W-1:0]        quot;

  always_comb begin
    case (term_q)
      2'd0:    begin sel_gain = req_i.gain[0]; sel_oper = req_i.oper[0]; end
      2'd1:    begin sel_gain = req_i.gain[1]; sel_oper = req_i.oper[1]; end
      default: begin sel_gain = req_i.gain[2]; sel_oper = req_i.oper[2]; end
    endcase
  end

  // Lower chunks are unsigned; only the top chunk carries the operand sign.
  assign chunk_bits = sel_oper[chunk_q*CHUNK_W +: CHUNK_W];
  assign chunk_ext  = (chunk_q == LAST_CHUNK) ? chunk_bits[CHUNK_W-1] : 1'b0;
  assign mult_d     = $signed({1'b0, sel_gain}) * $signed({chunk_ext, chunk_bits});
  assign issue_last = (term_q == LAST_TERM) && (chunk_q == LAST_CHUNK);

  assign addend = ACC_W'(mult_q);
  always_comb begin
    case (pend_chunk_q)
      2'd0:    addend_sh = addend;
      2'd1:    addend_sh = addend <<< CHUNK_W;
      default: addend_sh = addend <<< (2 * CHUNK_W);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q     <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      done_q      <= 1'b0;
      term_q      <= '0;
      chunk_q     <= '0;
    end else begin
      done_q <= pend_q && pend_last_q;
      pend_q <= issue_q;
      if (req_i.start) begin
        issue_q <= 1'b1;
        term_q  <= '0;
        chunk_q <= '0;
      end else if (issue_q) begin
        pend_last_q <= issue_last;
        if (chunk_q == LAST_CHUNK) begin
          chunk_q <= '0;
          term_q  <= term_q + TERM_W'(1);
        end else begin
          chunk_q <= chunk_q + CIDX_W'(1);
        end
        if (issue_last) begin
          issue_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_q) begin
      mult_q       <= mult_d;
      pend_chunk_q <= chunk_q;
    end
    if (req_i.start) begin
      acc_q <= '0;
    end else if (pend_q) begin
      acc_q <= acc_q + addend_sh;
    end
  end

  // Floor of the sum at 26 fraction bits, clamped to the duty range.
  assign quot = acc_q[ACC_W-1:SHIFT_OUT];
  always_comb begin
    if (quot[QUOT_W-1]) begin
      duty_o = '0;
    end else if (|quot[QUOT_W-2:DUTY_W]) begin
      duty_o = DUTY_W'(DUTY_MAX);
    end else begin
      duty_o = quot[DUTY_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: rtl/averaged_pid_fan_controller.sv
// Averaged PID fan controller: sequencer, PID state and configuration registers.
// A PID tick sums the probes, runs the serial divider, takes an error step and an integral
// step, runs the multiply-accumulate and emits the result; the next request is taken only
// once the sequencer is back in idle. Manual mode ends after the divider, no valid probe
// after the summing, door open goes straight to the emit step and a clear request emits
// nothing; a stalled result register holds the emit step. Reset clears the pause
// flag, the integral and the last error, and loads register defaults.
`default_nettype none

module averaged_pid_fan_controller import apfc_pkg::*; #(
  parameter int PROBE_COUNT = 5
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [WORD_W-1:0]    cfg_data_i,

  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 func_i,
  input  wire logic                 firebox_open_i,
  input  wire logic                 oven_open_i,
  input  wire logic [WORD_W-1:0]    probe0_word_i,
  input  wire logic [WORD_W-1:0]    probe1_word_i,
  input  wire logic [WORD_W-1:0]    probe2_word_i,
  input  wire logic [WORD_W-1:0]    probe3_word_i,
  input  wire logic [WORD_W-1:0]    probe4_word_i,

  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [DUTY_W-1:0]         fan_duty_o,
  output logic                      door_paused_o,
  output logic                      door_reclosed_o,
  output logic                      no_valid_probe_o,
  output logic                      manual_active_o,
  output logic signed [TEMP_W-1:0]  mean_temp_o
);

  localparam int USED   = (PROBE_COUNT < PROBE_FIELDS) ? PROBE_COUNT : PROBE_FIELDS;
  localparam int PIDX_W = (USED > 1) ? $clog2(USED) : 1;
  localparam int CNT_W  = $clog2(USED + 1);
  localparam logic [PIDX_W-1:0] LAST_PIDX = PIDX_W'(USED - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_ERR,
    ST_INT,
    ST_MAC,
    ST_EMIT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [TEMP_W-1:0] target_q;
  logic [GAIN_W-1:0] pgain_q;
  logic [GAIN_W-1:0] igain_q;
  logic [GAIN_W-1:0] dgain_q;
  logic              man_en_q;
  logic [DUTY_W-1:0] man_duty_q;

  // Controller state.
  logic              paused_q;
  logic [OPER_W-1:0] es_q;
  logic [ERR_W-1:0]  last_q;
  logic [PIDX_W-1:0] pidx_q;
  logic              out_valid_q;

  // Working and result registers.
  logic [WORD_W-1:0] probe_q [USED];
  logic [DVD_W-1:0]  sum_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ERR_W-1:0]  err_q;
  logic [DIFF_W-1:0] diff_q;
  logic [DUTY_W-1:0] res_duty_q;
  logic              res_paused_q;
  logic              res_reclosed_q;
  logic              res_novalid_q;
  logic              res_manual_q;
  logic [TEMP_W-1:0] res_mean_q;
  logic [DUTY_W-1:0] out_duty_q;
  logic              out_paused_q;
  logic              out_reclosed_q;
  logic              out_novalid_q;
  logic              out_manual_q;
  logic [TEMP_W-1:0] out_mean_q;

  logic [WORD_W-1:0] port_word [PROBE_FIELDS];
  logic              in_accept;
  logic              door_open;
  logic              out_free;
  logic              head_ok;
  logic [DVD_W-1:0]  sum_d;
  logic [CNT_W-1:0]  cnt_d;
  logic              sum_last;
  logic [OPER_W:0]   es_wide;
  logic [OPER_W-1:0] es_d;
  logic [ERR_W-1:0]  err_d;
  logic [DIFF_W-1:0] diff_d;
  div_req_t          div_req;
  logic              div_done;
  logic [TEMP_W-1:0] div_quot;
  mac_req_t          mac_req;
  logic              mac_done;
  logic [DUTY_W-1:0] mac_duty;

  assign port_word[0] = probe0_word_i;
  assign port_word[1] = probe1_word_i;
  assign port_word[2] = probe2_word_i;
  assign port_word[3] = probe3_word_i;
  assign port_word[4] = probe4_word_i;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign door_open  = firebox_open_i || oven_open_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  // One probe per cycle; faulted words are skipped.
  assign head_ok  = !probe_q[0][FAULT_BIT];
  assign sum_d    = sum_q + (head_ok ? DVD_W'($signed(probe_q[0])) : DVD_W'(0));
  assign cnt_d    = cnt_q + CNT_W'(head_ok);
  assign sum_last = (pidx_q == LAST_PIDX);

  assign err_d  = {target_q[TEMP_W-1], target_q} - {res_mean_q[TEMP_W-1], res_mean_q};
  assign diff_d = {err_q[ERR_W-1], err_q} - {last_q[ERR_W-1], last_q};

  // The integral saturates when the 49-bit sum leaves the 48-bit range.
  assign es_wide = {es_q[OPER_W-1], es_q} + (OPER_W+1)'($signed(err_q));
  always_comb begin
    if (es_wide[OPER_W] != es_wide[OPER_W-1]) begin
      es_d = {es_wide[OPER_W], {(OPER_W-1){~es_wide[OPER_W]}}};
    end else begin
      es_d = es_wide[OPER_W-1:0];
    end
  end

  assign div_req.start    = (state_q == ST_SUM) && sum_last && (cnt_d != '0);
  assign div_req.dividend = sum_d;
  assign div_req.divisor  = DSR_W'(cnt_d);

  apfc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign mac_req.start   = (state_q == ST_INT);
  assign mac_req.gain[0] = pgain_q;
  assign mac_req.gain[1] = igain_q;
  assign mac_req.gain[2] = dgain_q;
  assign mac_req.oper[0] = OPER_W'($signed(err_q));
  assign mac_req.oper[1] = es_q;
  assign mac_req.oper[2] = OPER_W'($signed(diff_q));

  apfc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .done_o (mac_done),
    .duty_o (mac_duty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= TARGET_RST;
      pgain_q    <= PGAIN_RST;
      igain_q    <= IGAIN_RST;
      dgain_q    <= DGAIN_RST;
      man_en_q   <= 1'b0;
      man_duty_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET:     target_q   <= cfg_data_i[TEMP_W-1:0];
        REG_PGAIN:      pgain_q    <= cfg_data_i[GAIN_W-1:0];
        REG_IGAIN:      igain_q    <= cfg_data_i[GAIN_W-1:0];
        REG_DGAIN:      dgain_q    <= cfg_data_i[GAIN_W-1:0];
        REG_MAN_ENABLE: man_en_q   <= cfg_data_i[0];
        REG_MAN_DUTY:   man_duty_q <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      paused_q    <= 1'b0;
      es_q        <= '0;
      last_q      <= '0;
      pidx_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (func_i) begin
              es_q   <= '0;
              last_q <= '0;
            end else if (door_open) begin
              paused_q <= 1'b1;
              state_q  <= ST_EMIT;
            end else begin
              paused_q <= 1'b0;
              pidx_q   <= '0;
              state_q  <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          pidx_q <= pidx_q + PIDX_W'(1);
          if (sum_last) begin
            state_q <= (cnt_d == '0) ? ST_EMIT : ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= man_en_q ? ST_EMIT : ST_ERR;
          end
        end
        ST_ERR: begin
          state_q <= ST_INT;
        end
        ST_INT: begin
          es_q    <= es_d;
          last_q  <= err_q;
          state_q <= ST_MAC;
        end
        ST_MAC: begin
          if (mac_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept && !func_i) begin
          for (int i = 0; i < USED; i++) begin
            probe_q[i] <= port_word[i];
          end
          sum_q          <= '0;
          cnt_q          <= '0;
          res_duty_q     <= '0;
          res_paused_q   <= door_open;
          res_reclosed_q <= !door_open && paused_q;
          res_novalid_q  <= 1'b0;
          res_manual_q   <= 1'b0;
          res_mean_q     <= '0;
        end
      end
      ST_SUM: begin
        for (int i = 0; i < USED - 1; i++) begin
          probe_q[i] <= probe_q[i+1];
        end
        sum_q <= sum_d;
        cnt_q <= cnt_d;
        if (sum_last && (cnt_d == '0)) begin
          res_novalid_q <= 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_mean_q <= div_quot;
          if (man_en_q) begin
            res_duty_q   <= man_duty_q;
            res_manual_q <= 1'b1;
          end
        end
      end
      ST_ERR: begin
        err_q <= err_d;
      end
      ST_INT: begin
        diff_q <= diff_d;
      end
      ST_MAC: begin
        if (mac_done) begin
          res_duty_q <= mac_duty;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_duty_q     <= res_duty_q;
          out_paused_q   <= res_paused_q;
          out_reclosed_q <= res_reclosed_q;
          out_novalid_q  <= res_novalid_q;
          out_manual_q   <= res_manual_q;
          out_mean_q     <= res_mean_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign fan_duty_o       = out_duty_q;
  assign door_paused_o    = out_paused_q;
  assign door_reclosed_o  = out_reclosed_q;
  assign no_valid_probe_o = out_novalid_q;
  assign manual_active_o  = out_manual_q;
  assign mean_temp_o      = out_mean_q;

  a_pause_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && door_paused_o |-> fan_duty_o == '0 && !door_reclosed_o
      && !no_valid_probe_o && !manual_active_o && mean_temp_o == '0)
    else $error("paused result carries nonzero fields");

  a_novalid_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_valid_probe_o |-> fan_duty_o == '0 && !manual_active_o
      && mean_temp_o == '0)
    else $error("result without valid probes drives the fan");

  a_clear_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && func_i |=> es_q == '0 && last_q == '0)
    else $error("clear request left PID history");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide step");

  a_mac_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> state_q == ST_MAC)
    else $error("multiply-accumulate finished outside its step");

endmodule

`default_nettype wire

FILE: tb/sv/tb_averaged_pid_fan_controller.sv
// Self-checking testbench for the averaged PID fan controller with a built-in duty predictor.
module tb_averaged_pid_fan_controller;
  import apfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PROBE_COUNT     = 5;
  localparam int PROBE_USED      = (PROBE_COUNT < PROBE_FIELDS) ? PROBE_COUNT : PROBE_FIELDS;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 229;
  localparam int DRAIN_GAP       = 100;
  localparam int CYCLE_LIMIT     = 12_000_000;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // Indexes beyond the register file; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic [WORD_W-1:0] FAULT_MASK = 32'h1 << FAULT_BIT;
  localparam logic [WORD_W-1:0] WORD_MIN   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX   = 32'h7EFF_FFFF;

  localparam logic signed [127:0] ISUM_MAX = (128'sd1 <<< (OPER_W - 1)) - 128'sd1;
  localparam logic signed [127:0] ISUM_MIN = -(128'sd1 <<< (OPER_W - 1));

  typedef struct packed {
    logic                                func;
    logic                                firebox_open;
    logic                                oven_open;
    logic [PROBE_FIELDS-1:0][WORD_W-1:0] probes;
    logic                                drain_first;
  } tick_req_t;

  typedef struct packed {
    logic [DUTY_W-1:0] fan_duty;
    logic              door_paused;
    logic              door_reclosed;
    logic              no_valid_probe;
    logic              manual_active;
    logic [TEMP_W-1:0] mean_temp;
  } duty_res_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [WORD_W-1:0]      cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   func_i = 1'b0;
  logic                   firebox_open_i = 1'b0;
  logic                   oven_open_i = 1'b0;
  logic [WORD_W-1:0]      probe0_word_i = '0;
  logic [WORD_W-1:0]      probe1_word_i = '0;
  logic [WORD_W-1:0]      probe2_word_i = '0;
  logic [WORD_W-1:0]      probe3_word_i = '0;
  logic [WORD_W-1:0]      probe4_word_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [DUTY_W-1:0]      fan_duty_o;
  logic                   door_paused_o;
  logic                   door_reclosed_o;
  logic                   no_valid_probe_o;
  logic                   manual_active_o;
  logic signed [TEMP_W-1:0] mean_temp_o;

  averaged_pid_fan_controller #(
    .PROBE_COUNT(PROBE_COUNT)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .func_i,
    .firebox_open_i,
    .oven_open_i,
    .probe0_word_i,
    .probe1_word_i,
    .probe2_word_i,
    .probe3_word_i,
    .probe4_word_i,
    .out_valid_o,
    .out_stall_i,
    .fan_duty_o,
    .door_paused_o,
    .door_reclosed_o,
    .no_valid_probe_o,
    .manual_active_o,
    .mean_temp_o
  );

  // Predictor copy of the configuration registers.
  logic signed [TEMP_W-1:0] setpoint_q = TARGET_RST;
  logic [GAIN_W-1:0]        pgain_q    = PGAIN_RST;
  logic [GAIN_W-1:0]        igain_q    = IGAIN_RST;
  logic [GAIN_W-1:0]        dgain_q    = DGAIN_RST;
  logic                     man_en_q   = 1'b0;
  logic [DUTY_W-1:0]        man_duty_q = '0;

  // Predictor copy of the controller state.
  logic                     paused_q   = 1'b0;
  logic signed [OPER_W-1:0] integ_q    = '0;
  logic signed [ERR_W-1:0]  prev_err_q = '0;

  tick_req_t tick_pending_q[$];
  duty_res_t duty_expect_q[$];
  tick_req_t cur_req;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        err_cnt        = 0;
  int        cycle_cnt      = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [WORD_W-1:0] data);
    case (idx)
      REG_TARGET:     setpoint_q = data;
      REG_PGAIN:      pgain_q    = data[GAIN_W-1:0];
      REG_IGAIN:      igain_q    = data[GAIN_W-1:0];
      REG_DGAIN:      dgain_q    = data[GAIN_W-1:0];
      REG_MAN_ENABLE: man_en_q   = data[0];
      REG_MAN_DUTY:   man_duty_q = data[DUTY_W-1:0];
      default: ;
    endcase
  endfunction

  // Works out the result of one request; returns 0 when the request yields none.
  function automatic bit predict_fan_duty(input tick_req_t req, output duty_res_t res);
    longint              probe_sum;
    longint              avg;
    int                  valid_cnt;
    logic signed [127:0] err_w, sum_w, dif_w, acc_w, gp_w, gi_w, gd_w;
    res = '0;
    if (req.func == FUNC_CLEAR) begin
      integ_q    = '0;
      prev_err_q = '0;
      return 1'b0;
    end
    if (req.firebox_open || req.oven_open) begin
      paused_q          = 1'b1;
      res.door_paused   = 1'b1;
      return 1'b1;
    end
    res.door_reclosed = paused_q;
    paused_q          = 1'b0;

    probe_sum = 0;
    valid_cnt = 0;
    for (int i = 0; i < PROBE_USED; i++) begin
      if (!req.probes[i][FAULT_BIT]) begin
        probe_sum += longint'($signed(req.probes[i]));
        valid_cnt++;
      end
    end
    if (valid_cnt == 0) begin
      res.no_valid_probe = 1'b1;
      return 1'b1;
    end
    // Signed division truncates toward zero.
    avg           = probe_sum / valid_cnt;
    res.mean_temp = avg[TEMP_W-1:0];
    if (man_en_q) begin
      res.fan_duty      = man_duty_q;
      res.manual_active = 1'b1;
      return 1'b1;
    end

    err_w = setpoint_q;
    err_w = err_w - avg;
    sum_w = integ_q;
    sum_w = sum_w + err_w;
    if (sum_w > ISUM_MAX) sum_w = ISUM_MAX;
    else if (sum_w < ISUM_MIN) sum_w = ISUM_MIN;
    integ_q    = sum_w[OPER_W-1:0];
    dif_w      = prev_err_q;
    dif_w      = err_w - dif_w;
    prev_err_q = err_w[ERR_W-1:0];

    gp_w  = pgain_q;
    gi_w  = igain_q;
    gd_w  = dgain_q;
    acc_w = (gp_w * err_w + gi_w * sum_w + gd_w * dif_w) >>> SHIFT_OUT;
    if (acc_w < 0) res.fan_duty = '0;
    else if (acc_w > DUTY_MAX) res.fan_duty = DUTY_W'(DUTY_MAX);
    else res.fan_duty = acc_w[DUTY_W-1:0];
    return 1'b1;
  endfunction

  function automatic tick_req_t make_req(input logic func, input logic fb, input logic ov,
                                         input logic [PROBE_FIELDS-1:0][WORD_W-1:0] words,
                                         input logic drain);
    tick_req_t r;
    r.func         = func;
    r.firebox_open = fb;
    r.oven_open    = ov;
    r.probes       = words;
    r.drain_first  = drain;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rand_probe_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 9))
      0: w = $urandom();
      1: w = $urandom_range(0, 600 * 1024) | FAULT_MASK;
      2: begin
        case ($urandom_range(0, 5))
          0:       w = '0;
          1:       w = 32'h00FF_FFFF;
          2:       w = WORD_MIN;
          3:       w = 32'hFEFF_FFFF;
          4:       w = WORD_MAX;
          default: w = 32'hFFFF_FFFF;
        endcase
      end
      default: w = $urandom_range(0, 600 * 1024);
    endcase
    return w;
  endfunction

  function automatic tick_req_t rand_tick();
    tick_req_t r;
    int        pick;
    r      = '0;
    r.func = ($urandom_range(0, 99) < 4) ? FUNC_CLEAR : FUNC_TICK;
    pick   = $urandom_range(0, 99);
    r.firebox_open = (pick < 8) || (pick >= 14 && pick < 17);
    r.oven_open    = (pick >= 8 && pick < 17);
    for (int i = 0; i < PROBE_FIELDS; i++) r.probes[i] = rand_probe_word();
    // Occasionally every probe is faulty.
    if ($urandom_range(0, 24) == 0) begin
      for (int i = 0; i < PROBE_FIELDS; i++) r.probes[i][FAULT_BIT] = 1'b1;
    end
    r.drain_first = ($urandom_range(0, 199) == 0);
    return r;
  endfunction

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    apply_reg(idx, data);
  endtask

  task automatic end_reg_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every request is taken and answered, then lets a clear request finish.
  task automatic wait_drained();
    while (tick_pending_q.size() != 0 || in_valid_i || duty_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Request driver.
  always @(posedge clk_i) begin
    duty_res_t res;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (predict_fan_duty(cur_req, res)) duty_expect_q.push_back(res);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tick_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(tick_pending_q[0].drain_first && duty_expect_q.size() != 0)) begin
          cur_req = tick_pending_q.pop_front();
          in_valid_i     <= 1'b1;
          func_i         <= cur_req.func;
          firebox_open_i <= cur_req.firebox_open;
          oven_open_i    <= cur_req.oven_open;
          probe0_word_i  <= cur_req.probes[0];
          probe1_word_i  <= cur_req.probes[1];
          probe2_word_i  <= cur_req.probes[2];
          probe3_word_i  <= cur_req.probes[3];
          probe4_word_i  <= cur_req.probes[4];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    duty_res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (duty_expect_q.size() == 0) begin
          $error("unexpected result: fan_duty %0d, mean_temp %0d", fan_duty_o, mean_temp_o);
          err_cnt++;
        end else begin
          want = duty_expect_q.pop_front();
          check_field("fan_duty", want.fan_duty, fan_duty_o);
          check_field("door_paused", want.door_paused, door_paused_o);
          check_field("door_reclosed", want.door_reclosed, door_reclosed_o);
          check_field("no_valid_probe", want.no_valid_probe, no_valid_probe_o);
          check_field("manual_active", want.manual_active, manual_active_o);
          check_field("mean_temp", longint'($signed(want.mean_temp)), longint'(mean_temp_o));
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [PROBE_FIELDS-1:0][WORD_W-1:0] warm;
    logic [PROBE_FIELDS-1:0][WORD_W-1:0] faulty;
    warm   = {32'(50 * 1024), 32'(45 * 1024), 32'(40 * 1024), 32'(35 * 1024), 32'(30 * 1024)};
    faulty = {32'hFFFF_FFFF, FAULT_MASK, 32'h7FFF_FFFF, 32'h0100_0000 | 32'(25 * 1024),
              32'hFF00_0000};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      case (ph)
        0: begin
          // Reset settings: directed requests first.
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b0, 1'b0, warm, 1'b0));
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b0, 1'b0, faulty, 1'b0));
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b0, 1'b0,
            {32'hFFFF_FFFF, 32'h0, 32'hFEFF_FFFF, 32'h00FF_FFFF, WORD_MIN}, 1'b0));
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b0, 1'b0,
            {faulty[4:1], 32'(33 * 1024)}, 1'b0));
          // Negative sum that does not divide evenly by three.
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b0, 1'b0,
            {FAULT_MASK, 32'hFE00_0001, 32'hFE00_0001, 32'hFFFF_FFFF, 32'hFE00_0000}, 1'b0));
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b1, 1'b0, warm, 1'b0));
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b0, 1'b1, warm, 1'b0));
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b1, 1'b1, warm, 1'b0));
          // A clear request while paused must not end the pause.
          tick_pending_q.push_back(make_req(FUNC_CLEAR, 1'b1, 1'b1, warm, 1'b0));
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b0, 1'b0, warm, 1'b0));
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b0, 1'b0, warm, 1'b0));
          tick_pending_q.push_back(make_req(FUNC_CLEAR, 1'b0, 1'b0, faulty, 1'b1));
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b0, 1'b0, warm, 1'b0));
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b1, 1'b0, faulty, 1'b0));
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b0, 1'b0, faulty, 1'b0));
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b0, 1'b0, {5{WORD_MAX}}, 1'b0));
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b0, 1'b0, {5{WORD_MIN}}, 1'b0));
          tick_pending_q.push_back(make_req(FUNC_TICK, 1'b0, 1'b0,
            {{4{32'hFEFF_FFFF}}, FAULT_MASK}, 1'b0));
        end
        1: begin
          program_reg(REG_TARGET, 32'h7FFF_FFFF);
          program_reg(REG_PGAIN, 32'h00FF_FFFF);
          program_reg(REG_IGAIN, 32'h00FF_FFFF);
          program_reg(REG_DGAIN, 32'h00FF_FFFF);
        end
        2: begin
          program_reg(REG_TARGET, WORD_MIN);
          program_reg(REG_PGAIN, 32'h0);
          program_reg(REG_IGAIN, 32'h0);
          program_reg(REG_DGAIN, 32'h0);
        end
        3: begin
          program_reg(REG_TARGET, 32'(40 * 1024));
          program_reg(REG_PGAIN, 32'h0001_0000);
          program_reg(REG_MAN_ENABLE, 32'h1);
          program_reg(REG_MAN_DUTY, 32'hFF);
        end
        4: begin
          program_reg(REG_MAN_DUTY, 32'h0);
          program_reg(REG_SPARE_A, $urandom());
          program_reg(REG_SPARE_B, $urandom());
        end
        5: begin
          program_reg(REG_MAN_ENABLE, 32'h0);
          program_reg(REG_TARGET, $urandom_range(0, 400 * 1024));
          program_reg(REG_PGAIN, $urandom_range(0, 32'h3_FFFF));
          program_reg(REG_IGAIN, $urandom_range(0, 32'h3_FFFF));
          program_reg(REG_DGAIN, $urandom_range(0, 32'h3_FFFF));
        end
        6: begin
          // Full-width random data; upper bits beyond each register are dropped.
          program_reg(REG_TARGET, $urandom());
          program_reg(REG_PGAIN, $urandom());
          program_reg(REG_IGAIN, $urandom());
          program_reg(REG_DGAIN, $urandom());
          program_reg(REG_MAN_ENABLE, $urandom());
          program_reg(REG_MAN_DUTY, $urandom());
        end
        default: begin
          program_reg(REG_MAN_ENABLE, 32'h0);
          program_reg(REG_TARGET, 32'(100 * 1024));
          program_reg(REG_PGAIN, 32'h0004_0000);
          program_reg(REG_IGAIN, 32'h0000_1999);
          program_reg(REG_DGAIN, 32'h0001_0000);
        end
      endcase
      if (ph != 0) end_reg_writes();
      repeat (ITEMS_PER_PHASE) tick_pending_q.push_back(rand_tick());
      wait_drained();
    end

    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
